[sv/gnm_pkg.sv]
// ----------------------------------------------------------------------------
// gnm_pkg
// Types, codes and default sizes shared by the nearest-reference matcher.
// ----------------------------------------------------------------------------
package gnm_pkg;

  localparam int DefMaxReferences = 16;
  localparam int DefCoordBits     = 8;

  localparam int KindBits   = 2;
  localparam int FaceBits   = 3;
  localparam int PortCoordW = 8;
  localparam int DistBits   = 10;
  localparam int IndexBits  = 4;
  localparam int SumBits    = 14;
  localparam int StatusBits = 2;

  localparam int DistMax = 1023;
  localparam int SumMax  = 16383;

  localparam logic [KindBits-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KindBits-1:0] KIND_APPEND = 2'd1;
  localparam logic [KindBits-1:0] KIND_ROUND  = 2'd2;
  localparam logic [KindBits-1:0] KIND_SCORE  = 2'd3;

  localparam logic [StatusBits-1:0] STATUS_OK      = 2'd0;
  localparam logic [StatusBits-1:0] STATUS_NO_FREE = 2'd1;
  localparam logic [StatusBits-1:0] STATUS_FULL    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage

[sv/gnm_in_if.sv]
// ----------------------------------------------------------------------------
// gnm_in_if
// Command channel of the matcher: valid/ready with one command item.
// ----------------------------------------------------------------------------
interface gnm_in_if;

  logic                               valid;
  logic                               ready;
  logic [gnm_pkg::KindBits-1:0]       kind;
  logic [gnm_pkg::FaceBits-1:0]       face;
  logic [gnm_pkg::PortCoordW-1:0]     row;
  logic [gnm_pkg::PortCoordW-1:0]     col;

  modport source (output valid, kind, face, row, col, input ready);
  modport sink   (input valid, kind, face, row, col, output ready);

endinterface

[sv/gnm_out_if.sv]
// ----------------------------------------------------------------------------
// gnm_out_if
// Result channel of the matcher: valid/ready with one result item.
// ----------------------------------------------------------------------------
interface gnm_out_if;

  logic                               valid;
  logic                               ready;
  logic [gnm_pkg::DistBits-1:0]       distance;
  logic [gnm_pkg::IndexBits-1:0]      match_index;
  logic [gnm_pkg::SumBits-1:0]        round_total;
  logic [gnm_pkg::StatusBits-1:0]     status;

  modport source (output valid, distance, match_index, round_total, status, input ready);
  modport sink   (input valid, distance, match_index, round_total, status, output ready);

endinterface

[sv/gnm_dist.sv]
// ----------------------------------------------------------------------------
// gnm_dist
// L1 distance between a stored reference triple and the candidate triple.
// ----------------------------------------------------------------------------
module gnm_dist #(
  parameter int COORD_BITS = gnm_pkg::DefCoordBits,
  parameter int DW         = 11
) (
  input  logic [gnm_pkg::FaceBits-1:0] ref_face,
  input  logic [COORD_BITS-1:0]        ref_row,
  input  logic [COORD_BITS-1:0]        ref_col,
  input  logic [gnm_pkg::FaceBits-1:0] cand_face,
  input  logic [COORD_BITS-1:0]        cand_row,
  input  logic [COORD_BITS-1:0]        cand_col,
  output logic [DW-1:0]                l1_dist
);
  import gnm_pkg::*;

  logic [FaceBits-1:0]   d_face;
  logic [COORD_BITS-1:0] d_row;
  logic [COORD_BITS-1:0] d_col;

  assign d_face = (ref_face > cand_face) ? ref_face - cand_face : cand_face - ref_face;
  assign d_row  = (ref_row > cand_row) ? ref_row - cand_row : cand_row - ref_row;
  assign d_col  = (ref_col > cand_col) ? ref_col - cand_col : cand_col - ref_col;

  assign l1_dist = DW'(d_face) + DW'(d_row) + DW'(d_col);

endmodule

[sv/greedy_nearest_l1_matcher.sv]
// ----------------------------------------------------------------------------
// greedy_nearest_l1_matcher
// Greedy nearest-reference matcher with L1 distance over a reference table.
// ----------------------------------------------------------------------------
// Usage:
//   cand carries command items (kind, face, row, col): clear table, append
//   reference, start new round, score candidate. res returns exactly one
//   result item per command (distance, match_index, round_total, status).
//   Commands are taken one at a time; cand.ready is high only while idle,
//   and it is high even when an earlier result still sits in the output
//   register.
//   Clear, append and new round go from accept through the finish state into
//   the output register. A score walks the reference memory one entry per
//   cycle through its single read port, then finishes the same way.
//   Once the result is loaded the block is idle and can take the next command.
//   Reset empties the table, the used bits and the running sum; the
//   reference memory itself is not cleared, entries past the count are
//   never compared. If res stalls, the finished result waits in the command's
//   last step until the output register frees up.
// ----------------------------------------------------------------------------
module greedy_nearest_l1_matcher #(
  parameter int MAX_REFERENCES = gnm_pkg::DefMaxReferences,
  parameter int COORD_BITS     = gnm_pkg::DefCoordBits
) (
  input  logic     clk,
  input  logic     rst,
  gnm_in_if.sink   cand,
  gnm_out_if.source res
);
  import gnm_pkg::*;

  localparam int IW  = (MAX_REFERENCES > 1) ? $clog2(MAX_REFERENCES) : 1;
  localparam int CNW = $clog2(MAX_REFERENCES + 1);
  localparam int CW  = COORD_BITS;
  localparam int KW  = (COORD_BITS < PortCoordW) ? COORD_BITS : PortCoordW;
  localparam int EW  = FaceBits + 2 * CW;
  localparam int DW  = (CW + 2 > DistBits + 1) ? CW + 2 : DistBits + 1;

  state_t state, state_next;

  // accepted command
  logic [KindBits-1:0] cmd_kind;
  logic [FaceBits-1:0] cmd_face;
  logic [CW-1:0]       cmd_row;
  logic [CW-1:0]       cmd_col;

  // table state
  logic [EW-1:0]             ref_mem [MAX_REFERENCES];
  logic [EW-1:0]             ref_rdata;
  logic [CNW-1:0]            ref_count;
  logic [MAX_REFERENCES-1:0] used;
  logic [SumBits-1:0]        dist_sum;

  // scan
  logic [CNW-1:0] rd_idx;
  logic           rd_issue;
  logic           cmp_valid;
  logic [IW-1:0]  cmp_idx;
  logic [DW-1:0]  cmp_dist;
  logic           found;
  logic [DW-1:0]  best;
  logic [IW-1:0]  best_idx;

  // output register
  logic                  out_valid;
  logic [DistBits-1:0]   out_distance;
  logic [IndexBits-1:0]  out_index;
  logic [SumBits-1:0]    out_total;
  logic [StatusBits-1:0] out_status;
  logic [DistBits-1:0]   out_distance_next;
  logic [IndexBits-1:0]  out_index_next;
  logic [SumBits-1:0]    out_total_next;
  logic [StatusBits-1:0] out_status_next;

  logic                take;
  logic                fin_go;
  logic                table_full;
  logic [DistBits-1:0] best_sat;
  logic [SumBits:0]    sum_add;
  logic [SumBits-1:0]  sum_sat;

  assign take       = cand.valid && cand.ready;
  assign table_full = (ref_count >= CNW'(MAX_REFERENCES));
  assign best_sat   = (best > DW'(DistMax)) ? DistBits'(DistMax) : best[DistBits-1:0];
  assign sum_add    = {1'b0, dist_sum} + (SumBits + 1)'(best_sat);
  assign sum_sat    = (sum_add > (SumBits + 1)'(SumMax)) ? SumBits'(SumMax)
                                                         : sum_add[SumBits-1:0];

  always_comb begin
    state_next = state;
    cand.ready = 1'b0;
    rd_issue   = 1'b0;
    fin_go     = 1'b0;
    case (state)
      ST_IDLE: begin
        cand.ready = 1'b1;
        if (cand.valid) begin
          state_next = (cand.kind == KIND_SCORE) ? ST_SCAN : ST_FINISH;
        end
      end
      ST_SCAN: begin
        if (rd_idx == ref_count) begin
          state_next = ST_FINISH;
        end else begin
          rd_issue = 1'b1;
        end
      end
      ST_FINISH: begin
        // wait for the last compare and for room in the output register
        if (!cmp_valid && (!out_valid || res.ready)) begin
          fin_go     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // command capture
  always_ff @(posedge clk) begin
    if (take) begin
      cmd_kind <= cand.kind;
      cmd_face <= cand.face;
      cmd_row  <= CW'(cand.row[KW-1:0]);
      cmd_col  <= CW'(cand.col[KW-1:0]);
    end
  end

  // reference memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (fin_go && cmd_kind == KIND_APPEND && !table_full) begin
      ref_mem[ref_count[IW-1:0]] <= {cmd_face, cmd_row, cmd_col};
    end
    ref_rdata <= ref_mem[rd_idx[IW-1:0]];
  end

  gnm_dist #(
    .COORD_BITS (CW),
    .DW         (DW)
  ) u_dist (
    .ref_face  (ref_rdata[EW-1 -: FaceBits]),
    .ref_row   (ref_rdata[2*CW-1 -: CW]),
    .ref_col   (ref_rdata[CW-1:0]),
    .cand_face (cmd_face),
    .cand_row  (cmd_row),
    .cand_col  (cmd_col),
    .l1_dist   (cmp_dist)
  );

  // scan: the read address leads the compare; the read data and its index are registered
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx    <= '0;
      cmp_valid <= 1'b0;
      found     <= 1'b0;
    end else begin
      cmp_valid <= rd_issue;
      if (take) begin
        rd_idx <= '0;
      end else if (rd_issue) begin
        rd_idx <= rd_idx + CNW'(1);
      end
      // strict less-than keeps the lowest index on a tie
      if (take) begin
        found <= 1'b0;
      end else if (cmp_valid && !used[cmp_idx] && (!found || cmp_dist < best)) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= rd_idx[IW-1:0];
    if (cmp_valid && !used[cmp_idx] && (!found || cmp_dist < best)) begin
      best     <= cmp_dist;
      best_idx <= cmp_idx;
    end
  end

  // table bookkeeping and result
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_count <= '0;
      used      <= '0;
      dist_sum  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fin_go) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      if (fin_go) begin
        case (cmd_kind)
          KIND_CLEAR: begin
            ref_count <= '0;
            used      <= '0;
            dist_sum  <= '0;
          end
          KIND_APPEND: begin
            if (!table_full) begin
              used[ref_count[IW-1:0]] <= 1'b0;
              ref_count               <= ref_count + CNW'(1);
            end
          end
          KIND_ROUND: begin
            used     <= '0;
            dist_sum <= '0;
          end
          KIND_SCORE: begin
            if (found) begin
              used[best_idx] <= 1'b1;
              dist_sum       <= sum_sat;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    out_distance_next = '0;
    out_index_next    = '0;
    out_status_next   = STATUS_OK;
    out_total_next    = dist_sum;
    case (cmd_kind)
      KIND_CLEAR, KIND_ROUND: begin
        out_total_next = '0;
      end
      KIND_APPEND: begin
        if (table_full) begin
          out_status_next = STATUS_FULL;
        end
      end
      KIND_SCORE: begin
        if (found) begin
          out_distance_next = best_sat;
          out_index_next    = IndexBits'(best_idx);
          out_total_next    = sum_sat;
        end else begin
          out_status_next = STATUS_NO_FREE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_distance <= out_distance_next;
      out_index    <= out_index_next;
      out_status   <= out_status_next;
      out_total    <= out_total_next;
    end
  end

  assign res.valid       = out_valid;
  assign res.distance    = out_distance;
  assign res.match_index = out_index;
  assign res.round_total = out_total;
  assign res.status      = out_status;

endmodule

[tb/greedy_nearest_l1_matcher_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_nearest_l1_matcher_tb
// Self-checking bench for the nearest-reference matcher: a directed opening
// (empty table, ties, exhausted round, full table, extreme triples) followed
// by random table builds, rounds and scored candidates, with random idling on
// both channels and one long result back-pressure window. Every result is
// compared field by field with an in-bench model of the table.
// ----------------------------------------------------------------------------
module greedy_nearest_l1_matcher_tb;
  import gnm_pkg::*;

  localparam int MaxRefs     = DefMaxReferences;
  localparam int CoordMask   = (1 << DefCoordBits) - 1;
  localparam int ItemTarget  = 1300;
  localparam int IdlePct     = 26;
  localparam int CalmStart   = 6000;
  localparam int CalmEnd     = 12000;
  localparam int HoldStart   = 1500;
  localparam int HoldCycles  = 400;
  localparam int DrainCycles = 40;
  localparam int CycleLimit  = 400000;

  typedef struct packed {
    logic [KindBits-1:0]   kind;
    logic [FaceBits-1:0]   face;
    logic [PortCoordW-1:0] row;
    logic [PortCoordW-1:0] col;
  } command_t;

  typedef struct packed {
    logic [DistBits-1:0]   distance;
    logic [IndexBits-1:0]  match_index;
    logic [SumBits-1:0]    round_total;
    logic [StatusBits-1:0] status;
  } match_result_t;

  logic clk;
  logic rst;

  gnm_in_if  cand_if ();
  gnm_out_if res_if ();

  greedy_nearest_l1_matcher u_dut (
    .clk  (clk),
    .rst  (rst),
    .cand (cand_if),
    .res  (res_if)
  );

  command_t      pending_cmds[$];
  command_t      history[$];
  match_result_t results_due[$];
  int            items_total;
  int            items_accepted;
  int            mismatches;
  int            cycle;
  int            hold_left;

  // model of the reference table
  command_t      tbl[MaxRefs];
  int            entry_count;
  logic [MaxRefs-1:0] taken_mask;
  int            dist_total;

  function automatic int gap(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic match_result_t apply_command(command_t c);
    match_result_t r;
    int            best;
    int            best_idx;
    int            d;
    bit            found;
    int            crow;
    int            ccol;
    r        = '0;
    found    = 0;
    best     = 0;
    best_idx = 0;
    crow     = int'(c.row) & CoordMask;
    ccol     = int'(c.col) & CoordMask;
    case (c.kind)
      KIND_CLEAR: begin
        entry_count = 0;
        taken_mask  = '0;
        dist_total  = 0;
      end
      KIND_APPEND: begin
        if (entry_count >= MaxRefs) begin
          r.status = STATUS_FULL;
        end else begin
          tbl[entry_count]      = c;
          tbl[entry_count].row  = PortCoordW'(crow);
          tbl[entry_count].col  = PortCoordW'(ccol);
          taken_mask[entry_count] = 1'b0;
          entry_count++;
        end
      end
      KIND_ROUND: begin
        taken_mask = '0;
        dist_total = 0;
      end
      default: begin
        for (int i = 0; i < entry_count; i++) begin
          if (!taken_mask[i]) begin
            d = gap(int'(tbl[i].face), int'(c.face)) + gap(int'(tbl[i].row), crow)
              + gap(int'(tbl[i].col), ccol);
            if (!found || d < best) begin
              found    = 1;
              best     = d;
              best_idx = i;
            end
          end
        end
        if (!found) begin
          r.status = STATUS_NO_FREE;
        end else begin
          if (best > DistMax) best = DistMax;
          taken_mask[best_idx] = 1'b1;
          dist_total = dist_total + best;
          if (dist_total > SumMax) dist_total = SumMax;
          r.distance    = best[DistBits-1:0];
          r.match_index = best_idx[IndexBits-1:0];
        end
      end
    endcase
    r.round_total = dist_total[SumBits-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic add_item(logic [KindBits-1:0] k, logic [FaceBits-1:0] f,
                          logic [PortCoordW-1:0] r, logic [PortCoordW-1:0] c);
    pending_cmds.insert(pending_cmds.size(), command_t'{k, f, r, c});
  endtask

  function automatic logic [PortCoordW-1:0] nudge(logic [PortCoordW-1:0] v);
    int x;
    x = int'(v) + $urandom_range(0, 8) - 4;
    if (x < 0) x = 0;
    if (x > 255) x = 255;
    return x[PortCoordW-1:0];
  endfunction

  function automatic bit idle_now();
    if (cycle >= CalmStart && cycle < CalmEnd) return 0;
    return $urandom_range(0, 99) < IdlePct;
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // long result stall: fills the block and blocks the command channel
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (cycle == HoldStart) begin
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // command driver
  always @(posedge clk) begin
    command_t c;
    if (rst) begin
      cand_if.valid <= 1'b0;
    end else begin
      if (cand_if.valid && cand_if.ready) begin
        c = command_t'{cand_if.kind, cand_if.face, cand_if.row, cand_if.col};
        results_due.insert(results_due.size(), apply_command(c));
        items_accepted++;
      end
      if (!cand_if.valid || cand_if.ready) begin
        if (pending_cmds.size() != 0 && !idle_now()) begin
          c = pending_cmds.pop_front();
          cand_if.valid <= 1'b1;
          cand_if.kind  <= c.kind;
          cand_if.face  <= c.face;
          cand_if.row   <= c.row;
          cand_if.col   <= c.col;
        end else begin
          cand_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    match_result_t want;
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("unexpected result, status", int'(res_if.status), 0);
        end else begin
          want = results_due.pop_front();
          if (res_if.distance !== want.distance)
            report_mismatch("distance", int'(res_if.distance), int'(want.distance));
          if (res_if.match_index !== want.match_index)
            report_mismatch("match_index", int'(res_if.match_index),
                            int'(want.match_index));
          if (res_if.round_total !== want.round_total)
            report_mismatch("round_total", int'(res_if.round_total),
                            int'(want.round_total));
          if (res_if.status !== want.status)
            report_mismatch("status", int'(res_if.status), int'(want.status));
        end
      end
      res_if.ready <= (hold_left == 0) && !idle_now();
    end
  end

  initial begin
    int       n;
    int       rounds;
    int       scores;
    command_t pick;
    rst            = 1'b1;
    cycle          = 0;
    mismatches     = 0;
    items_accepted = 0;
    entry_count    = 0;
    taken_mask     = '0;
    dist_total     = 0;
    cand_if.valid  = 1'b0;
    cand_if.kind   = KIND_CLEAR;
    cand_if.face   = '0;
    cand_if.row    = '0;
    cand_if.col    = '0;
    res_if.ready   = 1'b0;

    // directed opening
    add_item(KIND_SCORE, 3'd2, 8'd10, 8'd10);     // empty table
    add_item(KIND_APPEND, 3'd0, 8'd0, 8'd0);
    add_item(KIND_APPEND, 3'd7, 8'd255, 8'd255);
    add_item(KIND_APPEND, 3'd6, 8'd128, 8'd1);
    add_item(KIND_APPEND, 3'd0, 8'd0, 8'd0);      // duplicate for a tie
    add_item(KIND_SCORE, 3'd0, 8'd0, 8'd0);       // tie goes to the lower index
    add_item(KIND_SCORE, 3'd0, 8'd0, 8'd0);       // duplicate still free
    add_item(KIND_SCORE, 3'd0, 8'd0, 8'd0);
    add_item(KIND_SCORE, 3'd0, 8'd0, 8'd0);       // farthest extreme
    add_item(KIND_SCORE, 3'd5, 8'd64, 8'd200);    // round exhausted
    add_item(KIND_ROUND, 3'd0, 8'd0, 8'd0);
    add_item(KIND_SCORE, 3'd7, 8'd0, 8'd255);
    for (int i = 0; i < 12; i++) begin
      add_item(KIND_APPEND, 3'($urandom_range(0, 7)),
               (i % 3 == 0) ? 8'd255 : 8'($urandom),
               (i % 4 == 1) ? 8'd0 : 8'($urandom));
    end
    add_item(KIND_APPEND, 3'd1, 8'd1, 8'd1);      // table full
    add_item(KIND_SCORE, 3'd6, 8'd170, 8'd85);
    add_item(KIND_CLEAR, 3'd7, 8'd255, 8'd255);

    // random table builds, rounds and candidates
    while (pending_cmds.size() < ItemTarget) begin
      if ($urandom_range(0, 99) < 85) begin
        if (history.size() != 0 && $urandom_range(0, 3) == 0) begin
          add_item(KIND_ROUND, 3'($urandom), 8'($urandom), 8'($urandom));
        end else begin
          add_item(KIND_CLEAR, 3'($urandom), 8'($urandom), 8'($urandom));
          history.delete();
        end
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
          if (history.size() != 0 && $urandom_range(0, 4) == 0)
            pick = history[$urandom_range(0, history.size() - 1)];
          else
            pick = command_t'{KIND_APPEND, 3'($urandom_range(0, 7)),
                              8'($urandom), 8'($urandom)};
          add_item(KIND_APPEND, pick.face, pick.row, pick.col);
          if (history.size() < MaxRefs) history.insert(history.size(), pick);
        end
        rounds = $urandom_range(1, 3);
        for (int rr = 0; rr < rounds; rr++) begin
          add_item(KIND_ROUND, 3'($urandom), 8'($urandom), 8'($urandom));
          scores = $urandom_range(1, history.size() + 2);
          for (int s = 0; s < scores; s++) begin
            if ($urandom_range(0, 3) == 0) begin
              add_item(KIND_SCORE, 3'($urandom), 8'($urandom), 8'($urandom));
            end else begin
              pick = history[$urandom_range(0, history.size() - 1)];
              add_item(KIND_SCORE, ($urandom_range(0, 2) == 0) ? 3'($urandom) : pick.face,
                       nudge(pick.row), nudge(pick.col));
            end
            if ($urandom_range(0, 9) == 0) begin
              pick = command_t'{KIND_APPEND, 3'($urandom), 8'($urandom), 8'($urandom)};
              add_item(KIND_APPEND, pick.face, pick.row, pick.col);
              if (history.size() < MaxRefs) history.insert(history.size(), pick);
            end
          end
        end
      end else begin
        repeat ($urandom_range(1, 6))
          add_item(2'($urandom), 3'($urandom), 8'($urandom), 8'($urandom));
      end
    end
    items_total = pending_cmds.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (items_accepted < items_total || results_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
